// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and muted while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SRSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srsa_pkg.sv =====
// ----------------------------------------------------------------------------
// srsa_pkg
// Field widths, register indexes, rotation codes and pipeline control type
// of the scale and rotate source address generator.
// ----------------------------------------------------------------------------
package srsa_pkg;

  localparam int DEST_X_W    = 8;
  localparam int DEST_Y_W    = 9;
  localparam int SRC_COORD_W = 10;
  localparam int SRC_INDEX_W = 20;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int ROT_W       = 2;
  localparam int NSTAGE      = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION   = 2'd2;

  localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
  localparam logic [ROT_W-1:0] ROT_CW   = 2'd1;
  localparam logic [ROT_W-1:0] ROT_CCW  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 11'd320;
  localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 11'd240;

  // Load enables, one per pipeline stage.
  typedef struct packed {
    logic s1_en;
    logic s2_en;
    logic s3_en;
    logic s4_en;
    logic s5_en;
  } srsa_ctrl_t;

endpackage

// ===== hdl/srsa_if.sv =====
// ----------------------------------------------------------------------------
// srsa_if
// Valid/ready channels: destination coordinate in, source address out.
// ----------------------------------------------------------------------------
interface srsa_in_if import srsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DEST_X_W-1:0] dest_x;
  logic [DEST_Y_W-1:0] dest_y;

  modport source (output valid, output dest_x, output dest_y, input ready);
  modport sink   (input valid, input dest_x, input dest_y, output ready);
endinterface

interface srsa_out_if import srsa_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SRC_COORD_W-1:0] src_x;
  logic [SRC_COORD_W-1:0] src_y;
  logic [SRC_INDEX_W-1:0] src_index;

  modport source (output valid, output src_x, output src_y, output src_index,
                  input ready);
  modport sink   (input valid, input src_x, input src_y, input src_index,
                  output ready);
endinterface

// ===== hdl/srsa_axis.sv =====
// ----------------------------------------------------------------------------
// srsa_axis
// One axis of the scaler: (dest * size) / DISP, truncated, clamped to
// size - 1. Division by reciprocal multiply, three register stages.
// ----------------------------------------------------------------------------
module srsa_axis import srsa_pkg::*; #(
  parameter int DISP   = 240,
  parameter int D_BITS = 8,
  parameter int SW     = 11
) (
  input  logic              clk,
  input  srsa_ctrl_t        ctrl,
  input  logic [D_BITS-1:0] dest,
  input  logic [SW-1:0]     size,
  output logic [SW-1:0]     coord_r
);

  localparam int PW   = D_BITS + SW;
  localparam int KSH  = PW + $clog2(DISP);
  localparam int MW   = PW + 3;
  localparam int XW   = PW + MW;
  localparam int QW   = XW - KSH;
  localparam int CW   = (QW > SW) ? QW : SW;
  // Rounded-up reciprocal: exact for every product below 2**PW.
  localparam longint unsigned RECIP = ((64'd1 << KSH) + 64'(DISP) - 64'd1) / 64'(DISP);
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [PW-1:0] prod_r, prod_nxt;
  logic [XW-1:0] scaled_r, scaled_nxt;
  logic [QW-1:0] quot;
  logic [SW-1:0] coord_nxt;

  always_comb begin
    prod_nxt   = PW'(dest) * PW'(size);
    scaled_nxt = XW'(prod_r) * XW'(RECIP_C);
    quot       = scaled_r[XW-1:KSH];
    if (CW'(quot) >= CW'(size)) begin
      coord_nxt = size - SW'(1);
    end else begin
      coord_nxt = SW'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.s1_en) prod_r   <= prod_nxt;
    if (ctrl.s2_en) scaled_r <= scaled_nxt;
    if (ctrl.s3_en) coord_r  <= coord_nxt;
  end

endmodule

// ===== hdl/srsa_map.sv =====
// ----------------------------------------------------------------------------
// srsa_map
// Maps rotated coordinates back to source column and row, then forms the
// row-major index. Two register stages.
// ----------------------------------------------------------------------------
module srsa_map import srsa_pkg::*; #(
  parameter int SW = 11
) (
  input  logic                   clk,
  input  srsa_ctrl_t             ctrl,
  input  logic [ROT_W-1:0]       mode,
  input  logic [SW-1:0]          width,
  input  logic [SW-1:0]          height,
  input  logic [SW-1:0]          rx,
  input  logic [SW-1:0]          ry,
  output logic [SRC_COORD_W-1:0] src_x_r,
  output logic [SRC_COORD_W-1:0] src_y_r,
  output logic [SRC_INDEX_W-1:0] src_index_r
);

  localparam int OW = (SW > SRC_COORD_W) ? SW : SRC_COORD_W;
  localparam int IW = (2 * SW + 1 > SRC_INDEX_W) ? 2 * SW + 1 : SRC_INDEX_W;

  logic [SW-1:0]          sx_r, sx_nxt, sy_r, sy_nxt;
  logic [OW-1:0]          sx_ext, sy_ext;
  logic [IW-1:0]          index_full;
  logic [SRC_COORD_W-1:0] src_x_nxt, src_y_nxt;
  logic [SRC_INDEX_W-1:0] src_index_nxt;

  always_comb begin
    unique case (mode)
      ROT_CW: begin
        sx_nxt = width - SW'(1) - ry;
        sy_nxt = rx;
      end
      ROT_CCW: begin
        sx_nxt = ry;
        sy_nxt = height - SW'(1) - rx;
      end
      default: begin
        sx_nxt = rx;
        sy_nxt = ry;
      end
    endcase

    sx_ext        = OW'(sx_r);
    sy_ext        = OW'(sy_r);
    src_x_nxt     = sx_ext[SRC_COORD_W-1:0];
    src_y_nxt     = sy_ext[SRC_COORD_W-1:0];
    index_full    = IW'(sy_r) * IW'(width) + IW'(sx_r);
    src_index_nxt = index_full[SRC_INDEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.s4_en) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
    if (ctrl.s5_en) begin
      src_x_r     <= src_x_nxt;
      src_y_r     <= src_y_nxt;
      src_index_r <= src_index_nxt;
    end
  end

endmodule

// ===== hdl/scale_rotate_source_address.sv =====
// Throughput: one word per cycle; a full stage holds while the next one cannot take.
// Five stages: scale multiply, reciprocal multiply, clamp, rotate map, index MAC.
// Reset (rst_n low at a clock edge): valid bits cleared, source size 320 x 240,
// rotation clockwise. No clearing pass; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
// scale_rotate_source_address
// Nearest-neighbour scaler address generator with 90-degree rotation: takes a
// destination pixel and gives the source column, row and row-major index.
// ----------------------------------------------------------------------------
module scale_rotate_source_address import srsa_pkg::*; #(
  parameter int DEST_WIDTH     = 240,
  parameter int DEST_HEIGHT    = 320,
  parameter int MAX_SOURCE_DIM = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  srsa_in_if.sink                in_chan,
  srsa_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  // Effective size width, wide enough for MAX_SOURCE_DIM itself.
  localparam int SW = $clog2(MAX_SOURCE_DIM + 1);
  localparam int XW = (SW > CFG_DATA_W) ? SW : CFG_DATA_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] src_width_r, src_width_nxt;
  logic [CFG_DATA_W-1:0] src_height_r, src_height_nxt;
  logic [ROT_W-1:0]      rot_r, rot_nxt;

  always_comb begin
    src_width_nxt  = src_width_r;
    src_height_nxt = src_height_r;
    rot_nxt        = rot_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width_nxt  = cfg_wdata;
        REG_SRC_HEIGHT: src_height_nxt = cfg_wdata;
        REG_ROTATION: begin
          // the unused code is taken as clockwise
          if (cfg_wdata[ROT_W-1:0] > ROT_CCW) begin
            rot_nxt = ROT_CW;
          end else begin
            rot_nxt = cfg_wdata[ROT_W-1:0];
          end
        end
        default: ;  // beyond the register list: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= RST_SRC_WIDTH;
      src_height_r <= RST_SRC_HEIGHT;
      rot_r        <= ROT_CW;
    end else begin
      src_width_r  <= src_width_nxt;
      src_height_r <= src_height_nxt;
      rot_r        <= rot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Effective sizes. Zero is used as one, anything above MAX_SOURCE_DIM as
  // MAX_SOURCE_DIM; registers keep written bits. The user must change config
  // only with the pipe empty; not enforced. Every stage reads them directly.
  // --------------------------------------------------------------------------
  logic [XW-1:0] w_ext, h_ext;
  logic [SW-1:0] w_eff, h_eff, rot_w, rot_h;

  always_comb begin
    w_ext = XW'(src_width_r);
    h_ext = XW'(src_height_r);

    if (w_ext == '0) begin
      w_eff = SW'(1);
    end else if (w_ext > XW'(MAX_SOURCE_DIM)) begin
      w_eff = SW'(MAX_SOURCE_DIM);
    end else begin
      w_eff = SW'(w_ext);
    end

    if (h_ext == '0) begin
      h_eff = SW'(1);
    end else if (h_ext > XW'(MAX_SOURCE_DIM)) begin
      h_eff = SW'(MAX_SOURCE_DIM);
    end else begin
      h_eff = SW'(h_ext);
    end

    // rotated modes swap width and height
    rot_w = (rot_r == ROT_NONE) ? w_eff : h_eff;
    rot_h = (rot_r == ROT_NONE) ? h_eff : w_eff;
  end

  // --------------------------------------------------------------------------
  // Pipeline control. A stage takes a new word when it is empty or the stage
  // after it takes its word; the ready chain runs back from the output.
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld_r, vld_nxt, rdy;
  srsa_ctrl_t        ctrl;

  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_chan.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end

    vld_nxt = vld_r;
    if (rdy[0]) vld_nxt[0] = in_chan.valid;
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctrl.s1_en = rdy[0];
  assign ctrl.s2_en = rdy[1];
  assign ctrl.s3_en = rdy[2];
  assign ctrl.s4_en = rdy[3];
  assign ctrl.s5_en = rdy[4];

  assign in_chan.ready  = rdy[0];
  assign out_chan.valid = vld_r[NSTAGE-1];

  // --------------------------------------------------------------------------
  // Datapath: stages 1-3 scale each axis, stages 4-5 un-rotate and index.
  // --------------------------------------------------------------------------
  logic [SW-1:0] rx_r, ry_r;

  srsa_axis #(
    .DISP   (DEST_WIDTH),
    .D_BITS (DEST_X_W),
    .SW     (SW)
  ) u_axis_x (
    .clk     (clk),
    .ctrl    (ctrl),
    .dest    (in_chan.dest_x),
    .size    (rot_w),
    .coord_r (rx_r)
  );

  srsa_axis #(
    .DISP   (DEST_HEIGHT),
    .D_BITS (DEST_Y_W),
    .SW     (SW)
  ) u_axis_y (
    .clk     (clk),
    .ctrl    (ctrl),
    .dest    (in_chan.dest_y),
    .size    (rot_h),
    .coord_r (ry_r)
  );

  srsa_map #(
    .SW (SW)
  ) u_map (
    .clk         (clk),
    .ctrl        (ctrl),
    .mode        (rot_r),
    .width       (w_eff),
    .height      (h_eff),
    .rx          (rx_r),
    .ry          (ry_r),
    .src_x_r     (out_chan.src_x),
    .src_y_r     (out_chan.src_y),
    .src_index_r (out_chan.src_index)
  );

endmodule

// ===== hdl/srsa_checker.sv =====
// ----------------------------------------------------------------------------
// srsa_checker
// Port-level checks of the address generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module srsa_checker import srsa_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SRC_COORD_W-1:0] out_src_x,
  input logic [SRC_COORD_W-1:0] out_src_y,
  input logic [SRC_INDEX_W-1:0] out_src_index
);

  // a stalled result word holds
  `SRSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
                    "result word dropped while stalled")
  `SRSA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
                    $stable(out_src_x) && $stable(out_src_y) && $stable(out_src_index),
                    "result word changed while stalled")

  // input only backs up when every stage is full and the output is stalled
  `SRSA_ASSERT_NOW(a_in_block, !in_ready, out_valid && !out_ready,
                   "input stalled with room in the pipe")

  // a waiting input word stays offered until taken
  `SRSA_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid,
                    "input word withdrawn before it was taken")

  // first cycle out of reset: pipe empty, input open
  `SRSA_ASSERT_NOW(a_reset_empty, !$past(rst_n), in_ready && !out_valid,
                   "pipe not empty after reset")

endmodule

bind scale_rotate_source_address srsa_checker u_srsa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_src_x     (out_chan.src_x),
  .out_src_y     (out_chan.src_y),
  .out_src_index (out_chan.src_index)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scale and rotate source address generator.
// Destination pixels are pushed through the valid/ready input with random
// gaps. A local model of the scaler predicts the source column, row and
// index of every accepted word, and each output word is checked in order.
// ----------------------------------------------------------------------------
module tb import srsa_pkg::*; ();

  // Display geometry and the source size cap, as the block is built here.
  localparam int DISPLAY_W     = 240;
  localparam int DISPLAY_H     = 320;
  localparam int SIZE_CAP      = 1024;

  // Index with no register behind it; writes there must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int PRESSURE_HOLD = 64;          // output held off, in cycles
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_WORDS   = 92;
  localparam int RUN_LIMIT     = 12_000_000;  // watchdog limit, in time units

  typedef struct packed {
    logic [SRC_COORD_W-1:0] src_x;
    logic [SRC_COORD_W-1:0] src_y;
    logic [SRC_INDEX_W-1:0] src_index;
  } src_addr_t;

  logic                   clk   = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  srsa_in_if  in_chan ();
  srsa_out_if out_chan ();

  // Local copy of the register file, updated on every write the block sees.
  logic [CFG_DATA_W-1:0] shadow_width    = RST_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] shadow_height   = RST_SRC_HEIGHT;
  logic [ROT_W-1:0]      shadow_rotation = ROT_CW;

  src_addr_t expected_sources[$];
  int        field_errors       = 0;

  // Idling controls: percent chance of a gap before a word (sender) or of a
  // stall (receiver); a non-zero hold asks the receiver for one long stall.
  int        in_gap_pct         = 0;
  int        out_stall_pct      = 0;
  int        output_hold_cycles = 0;

  scale_rotate_source_address #(
    .DEST_WIDTH     (DISPLAY_W),
    .DEST_HEIGHT    (DISPLAY_H),
    .MAX_SOURCE_DIM (SIZE_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.dest_x = '0;
    in_chan.dest_y = '0;
    out_chan.ready = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Scaler model
  // --------------------------------------------------------------------------

  // Zero reads as one, anything past the cap as the cap; register keeps bits.
  function automatic int unsigned used_size(logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIZE_CAP) return SIZE_CAP;
    return 32'(v);
  endfunction

  // Truncating nearest-neighbour scale, clamped to the last row or column
  // (only bites when the destination lies off the display).
  function automatic int unsigned scaled(int unsigned d, int unsigned size,
                                         int unsigned disp);
    int unsigned r;
    r = (d * size) / disp;
    return (r >= size) ? size - 1 : r;
  endfunction

  function automatic src_addr_t predict_source(logic [DEST_X_W-1:0] dx,
                                               logic [DEST_Y_W-1:0] dy);
    int unsigned w, h, rot_w, rot_h, rx, ry, sx, sy;
    src_addr_t   a;
    w     = used_size(shadow_width);
    h     = used_size(shadow_height);
    // rotated modes swap the rotated width and height
    rot_w = (shadow_rotation == ROT_NONE) ? w : h;
    rot_h = (shadow_rotation == ROT_NONE) ? h : w;
    rx    = scaled(32'(dx), rot_w, DISPLAY_W);
    ry    = scaled(32'(dy), rot_h, DISPLAY_H);
    case (shadow_rotation)
      ROT_CW: begin
        sx = w - 1 - ry;
        sy = rx;
      end
      ROT_CCW: begin
        sx = ry;
        sy = h - 1 - rx;
      end
      default: begin
        sx = rx;
        sy = ry;
      end
    endcase
    a.src_x     = SRC_COORD_W'(sx);
    a.src_y     = SRC_COORD_W'(sy);
    a.src_index = SRC_INDEX_W'(sy * w + sx);
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input handshake, check on output handshake.
  // Config only changes while idle, so the shadow is valid at acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    src_addr_t want;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready)
        expected_sources.push_back(predict_source(in_chan.dest_x, in_chan.dest_y));
      if (out_chan.valid && out_chan.ready) begin
        if (expected_sources.size() == 0) begin
          $error("result word with nothing outstanding: src_x %0d src_y %0d index %0d",
                 out_chan.src_x, out_chan.src_y, out_chan.src_index);
          field_errors++;
        end else begin
          want = expected_sources.pop_front();
          if (out_chan.src_x !== want.src_x) begin
            $error("src_x: expected %0d, actual %0d", want.src_x, out_chan.src_x);
            field_errors++;
          end
          if (out_chan.src_y !== want.src_y) begin
            $error("src_y: expected %0d, actual %0d", want.src_y, out_chan.src_y);
            field_errors++;
          end
          if (out_chan.src_index !== want.src_index) begin
            $error("src_index: expected %0d, actual %0d",
                   want.src_index, out_chan.src_index);
            field_errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly short idles, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Receiver: at most one assignment to ready per edge; stalls counted here.
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (output_hold_cycles != 0) begin
        n = output_hold_cycles;
        output_hold_cycles = 0;
        out_chan.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        n = idle_length();
        out_chan.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Offers one word and returns at the edge that takes it. Valid is left
  // high so back-to-back words need no dead cycle.
  task automatic send_pixel(logic [DEST_X_W-1:0] x, logic [DEST_Y_W-1:0] y);
    int gap;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      gap = idle_length();
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.dest_x <= x;
    in_chan.dest_y <= y;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Drops valid, then waits for every outstanding word plus pipeline depth.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_sources.size() != 0) @(posedge clk);
    repeat (NSTAGE + 2) @(posedge clk);
  endtask

  // One register write; enable drops for a cycle after so writes never
  // collide in the same step.
  task automatic write_word(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_SRC_WIDTH:  shadow_width  = data;
      REG_SRC_HEIGHT: shadow_height = data;
      // the one unused code is stored as clockwise
      REG_ROTATION:   shadow_rotation = (data[ROT_W-1:0] > ROT_CCW) ? ROT_CW
                                                                     : data[ROT_W-1:0];
      default: ;      // unmapped, dropped by the block
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_image(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                               logic [CFG_DATA_W-1:0] rot);
    wait_idle();
    write_word(REG_SRC_WIDTH,  w);
    write_word(REG_SRC_HEIGHT, h);
    write_word(REG_ROTATION,   rot);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(1);
      2:       return CFG_DATA_W'(SIZE_CAP);
      3:       return CFG_DATA_W'($urandom_range(SIZE_CAP + 1, (1 << CFG_DATA_W) - 1));
      default: return CFG_DATA_W'($urandom_range(1, SIZE_CAP));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset values: 320 x 240 rotated clockwise. Corners plus a word past
  // the display edge to hit the clamp.
  task automatic test_reset_state();
    in_gap_pct    = 20;
    out_stall_pct = 20;
    send_pixel('0, '0);
    send_pixel(DEST_X_W'(DISPLAY_W - 1), DEST_Y_W'(DISPLAY_H - 1));
    send_pixel(DEST_X_W'(DISPLAY_W - 1), '0);
    send_pixel('0, DEST_Y_W'(DISPLAY_H - 1));
    send_pixel('1, '1);
  endtask

  // Each rotation, then the unused code with junk in the upper bits.
  task automatic test_rotations();
    logic [CFG_DATA_W-1:0] rot_words[4];
    rot_words = '{CFG_DATA_W'(ROT_NONE), CFG_DATA_W'(ROT_CW),
                  CFG_DATA_W'(ROT_CCW), '1};
    foreach (rot_words[i]) begin
      program_image(RST_SRC_WIDTH, RST_SRC_HEIGHT, rot_words[i]);
      send_pixel('0, '0);
      send_pixel(DEST_X_W'(DISPLAY_W - 1), DEST_Y_W'(DISPLAY_H - 1));
      send_pixel(DEST_X_W'(DISPLAY_W / 2), DEST_Y_W'(DISPLAY_H / 3));
    end
  endtask

  // Zero sizes read as one, oversize ones as the cap; largest index last.
  task automatic test_size_limits();
    program_image('0, '0, CFG_DATA_W'(ROT_NONE));
    send_pixel(DEST_X_W'(DISPLAY_W - 1), DEST_Y_W'(DISPLAY_H - 1));
    program_image('1, 11'd1500, CFG_DATA_W'(ROT_CCW));
    send_pixel('0, '0);
    send_pixel(DEST_X_W'(DISPLAY_W - 1), DEST_Y_W'(DISPLAY_H - 1));
    program_image(CFG_DATA_W'(1), CFG_DATA_W'(SIZE_CAP), CFG_DATA_W'(ROT_CW));
    send_pixel(DEST_X_W'(DISPLAY_W - 1), DEST_Y_W'(DISPLAY_H - 1));
    program_image(CFG_DATA_W'(SIZE_CAP), CFG_DATA_W'(SIZE_CAP), CFG_DATA_W'(ROT_NONE));
    send_pixel('1, '1);
  endtask

  // A write to the spare index must leave the mapping as it was.
  task automatic test_unmapped_register();
    wait_idle();
    write_word(REG_UNMAPPED, '1);
    send_pixel(DEST_X_W'(100), DEST_Y_W'(100));
    send_pixel(DEST_X_W'(DISPLAY_W - 1), DEST_Y_W'(DISPLAY_H - 1));
  endtask

  // Long output stall while the sender keeps pushing: pipe fills, input
  // ready must drop and nothing may be lost or duplicated.
  task automatic test_output_hold();
    wait_idle();
    in_gap_pct         = 0;
    out_stall_pct      = 0;
    output_hold_cycles = PRESSURE_HOLD;
    repeat (30)
      send_pixel(DEST_X_W'($urandom_range(0, DISPLAY_W - 1)),
                 DEST_Y_W'($urandom_range(0, DISPLAY_H - 1)));
  endtask

  // Random image sizes and rotations per phase; idling style rotates so
  // some phases run flat out on both sides.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] rot;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      rot = CFG_DATA_W'($urandom);
      if ($urandom_range(0, 5) != 0) rot[ROT_W-1:0] = ROT_W'($urandom_range(0, 2));
      program_image(random_size(), random_size(), rot);
      if ($urandom_range(0, 3) == 0) write_word(REG_UNMAPPED, CFG_DATA_W'($urandom));
      case (p % 3)
        0: begin
          in_gap_pct    = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_gap_pct    = 30;
          out_stall_pct = 0;
        end
        default: begin
          in_gap_pct    = 30;
          out_stall_pct = 25;
        end
      endcase
      repeat (PHASE_WORDS) begin
        // mostly on-screen, some anywhere in the field range
        if ($urandom_range(0, 9) == 0)
          send_pixel(DEST_X_W'($urandom), DEST_Y_W'($urandom));
        else
          send_pixel(DEST_X_W'($urandom_range(0, DISPLAY_W - 1)),
                     DEST_Y_W'($urandom_range(0, DISPLAY_H - 1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_rotations();
    test_size_limits();
    test_unmapped_register();
    test_output_hold();
    test_random_traffic();

    wait_idle();
    if (field_errors == 0 && expected_sources.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #RUN_LIMIT;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== scale_rotate_source_address.f =====
+incdir+hdl
hdl/srsa_pkg.sv
hdl/srsa_if.sv
hdl/srsa_axis.sv
hdl/srsa_map.sv
hdl/scale_rotate_source_address.sv
hdl/srsa_checker.sv
bench/tb.sv
